// ===== hdl/aesp_pkg.sv =====
// Shared types and constants of the escape sequence parser.
// No dependencies.
package aesp_pkg;

  localparam int PARAM_SLOTS = 16;
  localparam int PARAM_BITS  = 16;
  localparam int INTER_SLOTS = 2;
  localparam int CODE_BITS   = 21;

  // action kinds seen on the result port, plus internal-only ones
  localparam logic [3:0] K_PRINT     = 4'd0;
  localparam logic [3:0] K_EXEC      = 4'd1;
  localparam logic [3:0] K_ESC       = 4'd2;
  localparam logic [3:0] K_CSI       = 4'd3;
  localparam logic [3:0] K_HOOK      = 4'd4;
  localparam logic [3:0] K_PUT       = 4'd5;
  localparam logic [3:0] K_UNHOOK    = 4'd6;
  localparam logic [3:0] K_OSC_START = 4'd7;
  localparam logic [3:0] K_OSC_END   = 4'd8;
  localparam logic [3:0] K_PARAM     = 4'd12;
  localparam logic [3:0] K_COLLECT   = 4'd13;
  localparam logic [3:0] K_NONE      = 4'd15;

  typedef enum logic [3:0] {
    S_GROUND, S_ESC, S_ESC_INT, S_CSI_ENTRY, S_CSI_PARAM, S_CSI_INT,
    S_CSI_IGN, S_DCS_ENTRY, S_DCS_PARAM, S_DCS_INT, S_DCS_PASS,
    S_DCS_IGN, S_OSC, S_SOS
  } pstate_e;

  typedef logic [PARAM_BITS-1:0] pword_t;

  // one classified item: up to three output actions, packed from slot 0
  typedef struct packed {
    logic [CODE_BITS-1:0]        code;
    logic [2:0][3:0]             ops;
    logic [1:0]                  n_ops;
    logic [INTER_SLOTS-1:0][7:0] ibytes;
    logic [1:0]                  icount;
    logic                        iovf;
    logic [4:0]                  ptotal;
    logic [PARAM_SLOTS-1:0][PARAM_BITS-1:0] params;
  } job_t;

endpackage

// ===== hdl/aesp_front.sv =====
// Front end (uses aesp_pkg): folds and classifies each item, keeps parser
// state and param/intermediate collectors; emits a job per item with actions.
module aesp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [aesp_pkg::CODE_BITS-1:0] code_point_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output aesp_pkg::job_t                job_o
);

  aesp_pkg::pstate_e state_q, state_d;
  aesp_pkg::pword_t [aesp_pkg::PARAM_SLOTS-1:0] pv_q, pv_d, pv_n;
  logic [4:0] pc_q, pc_d, pc_n, pc_eff;
  logic [aesp_pkg::INTER_SLOTS-1:0][7:0] ib_q, ib_d, ib_n;
  logic [1:0] ic_q, ic_d, ic_n;
  logic       ov_q, ov_d, ov_n;

  logic [aesp_pkg::CODE_BITS-1:0] c;
  logic        is_c0, digit, inter, priv, any_hit, changed, clear, accept;
  logic [3:0]  na, exit_k, main_k, entry_k;
  aesp_pkg::pstate_e ns;
  logic [19:0] prod;
  logic [3:0]  pidx;
  logic [2:0][3:0] ops;
  logic [1:0]  n_ops;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    c = code_point_i;
    if (code_point_i >= 21'h0a0 && code_point_i <= 21'h0ff) c = code_point_i - 21'h080;
    is_c0 = c <= 21'h17 || c == 21'h19 || (c >= 21'h1c && c <= 21'h1f);
    digit = (c >= 21'h30 && c <= 21'h39) || c == 21'h3b;
    inter = c >= 21'h20 && c <= 21'h2f;
    priv  = c >= 21'h3c && c <= 21'h3f;

    // anywhere rules
    any_hit = 1'b1;
    na      = aesp_pkg::K_NONE;
    ns      = aesp_pkg::S_GROUND;
    if (c == 21'h18 || c == 21'h1a || (c >= 21'h80 && c <= 21'h8f) ||
        (c >= 21'h91 && c <= 21'h97) || c == 21'h99 || c == 21'h9a) begin
      na = aesp_pkg::K_EXEC;
    end else if (c == 21'h9c) begin
      ns = aesp_pkg::S_GROUND;
    end else if (c == 21'h98 || c == 21'h9e || c == 21'h9f) begin
      ns = aesp_pkg::S_SOS;
    end else if (c == 21'h1b) begin
      ns = aesp_pkg::S_ESC;
    end else if (c == 21'h90) begin
      ns = aesp_pkg::S_DCS_ENTRY;
    end else if (c == 21'h9d) begin
      ns = aesp_pkg::S_OSC;
    end else if (c == 21'h9b) begin
      ns = aesp_pkg::S_CSI_ENTRY;
    end else begin
      any_hit = 1'b0;
      ns      = state_q;
      unique case (state_q)
        aesp_pkg::S_GROUND: begin
          na = is_c0 ? aesp_pkg::K_EXEC : aesp_pkg::K_PRINT;
        end
        aesp_pkg::S_ESC: begin
          if (is_c0) na = aesp_pkg::K_EXEC;
          else if (c == 21'h7f) na = aesp_pkg::K_NONE;
          else if (inter) begin ns = aesp_pkg::S_ESC_INT; na = aesp_pkg::K_COLLECT; end
          else if (c == 21'h50) ns = aesp_pkg::S_DCS_ENTRY;
          else if (c == 21'h58 || c == 21'h5e || c == 21'h5f) ns = aesp_pkg::S_SOS;
          else if (c == 21'h5d) ns = aesp_pkg::S_OSC;
          else if (c == 21'h5b) ns = aesp_pkg::S_CSI_ENTRY;
          else if (c >= 21'h30) begin ns = aesp_pkg::S_GROUND; na = aesp_pkg::K_ESC; end
        end
        aesp_pkg::S_ESC_INT: begin
          if (is_c0) na = aesp_pkg::K_EXEC;
          else if (inter) na = aesp_pkg::K_COLLECT;
          else if (c >= 21'h30 && c <= 21'h7e) begin
            ns = aesp_pkg::S_GROUND; na = aesp_pkg::K_ESC;
          end
        end
        aesp_pkg::S_CSI_ENTRY, aesp_pkg::S_CSI_PARAM: begin
          if (is_c0) na = aesp_pkg::K_EXEC;
          else if (c == 21'h7f) na = aesp_pkg::K_NONE;
          else if (inter) begin ns = aesp_pkg::S_CSI_INT; na = aesp_pkg::K_COLLECT; end
          else if (digit) begin ns = aesp_pkg::S_CSI_PARAM; na = aesp_pkg::K_PARAM; end
          else if (c == 21'h3a) ns = aesp_pkg::S_CSI_IGN;
          else if (priv) begin
            if (state_q == aesp_pkg::S_CSI_ENTRY) begin
              ns = aesp_pkg::S_CSI_PARAM; na = aesp_pkg::K_COLLECT;
            end else ns = aesp_pkg::S_CSI_IGN;
          end else if (c >= 21'h40) begin ns = aesp_pkg::S_GROUND; na = aesp_pkg::K_CSI; end
        end
        aesp_pkg::S_CSI_INT: begin
          if (is_c0) na = aesp_pkg::K_EXEC;
          else if (inter) na = aesp_pkg::K_COLLECT;
          else if (c >= 21'h30 && c <= 21'h3f) ns = aesp_pkg::S_CSI_IGN;
          else if (c >= 21'h40 && c != 21'h7f) begin
            ns = aesp_pkg::S_GROUND; na = aesp_pkg::K_CSI;
          end
        end
        aesp_pkg::S_CSI_IGN: begin
          if (is_c0) na = aesp_pkg::K_EXEC;
          else if (c >= 21'h40 && c != 21'h7f) ns = aesp_pkg::S_GROUND;
        end
        aesp_pkg::S_DCS_ENTRY, aesp_pkg::S_DCS_PARAM: begin
          if (is_c0 || c == 21'h7f) na = aesp_pkg::K_NONE;
          else if (inter) begin ns = aesp_pkg::S_DCS_INT; na = aesp_pkg::K_COLLECT; end
          else if (digit) begin ns = aesp_pkg::S_DCS_PARAM; na = aesp_pkg::K_PARAM; end
          else if (c == 21'h3a) ns = aesp_pkg::S_DCS_IGN;
          else if (priv) begin
            if (state_q == aesp_pkg::S_DCS_ENTRY) begin
              ns = aesp_pkg::S_DCS_PARAM; na = aesp_pkg::K_COLLECT;
            end else ns = aesp_pkg::S_DCS_IGN;
          end else if (c >= 21'h40) ns = aesp_pkg::S_DCS_PASS;
        end
        aesp_pkg::S_DCS_INT: begin
          if (inter) na = aesp_pkg::K_COLLECT;
          else if (c >= 21'h30 && c <= 21'h3f) ns = aesp_pkg::S_DCS_IGN;
          else if (c >= 21'h40 && c != 21'h7f) ns = aesp_pkg::S_DCS_PASS;
        end
        aesp_pkg::S_DCS_PASS: begin
          if (c != 21'h7f) na = aesp_pkg::K_PUT;
        end
        default: ;
      endcase
    end
    changed = any_hit || (ns != state_q);

    // collectors after this item's own action
    pv_n   = pv_q;
    pc_n   = pc_q;
    ib_n   = ib_q;
    ic_n   = ic_q;
    ov_n   = ov_q;
    pc_eff = (pc_q == 5'd0) ? 5'd1 : pc_q;
    pidx   = pc_eff[3:0] - 4'd1;
    prod   = {4'd0, pv_q[pidx]} * 20'd10 + {16'd0, c[3:0]};
    if (na == aesp_pkg::K_COLLECT) begin
      if (ic_q >= 2'(aesp_pkg::INTER_SLOTS)) ov_n = 1'b1;
      else begin
        ib_n[ic_q[0]] = c[7:0];
        ic_n          = ic_q + 2'd1;
      end
    end else if (na == aesp_pkg::K_PARAM && pc_q <= 5'(aesp_pkg::PARAM_SLOTS)) begin
      pc_n = pc_eff;
      if (c == 21'h3b) begin
        if (pc_eff >= 5'(aesp_pkg::PARAM_SLOTS)) pc_n = 5'(aesp_pkg::PARAM_SLOTS + 1);
        else begin
          pv_n[pc_eff[3:0]] = '0;
          pc_n              = pc_eff + 5'd1;
        end
      end else begin
        pv_n[pidx] = (prod[19:16] != 4'd0) ? 16'hffff : prod[15:0];
      end
    end

    exit_k = aesp_pkg::K_NONE;
    if (changed && state_q == aesp_pkg::S_DCS_PASS) exit_k = aesp_pkg::K_UNHOOK;
    else if (changed && state_q == aesp_pkg::S_OSC) exit_k = aesp_pkg::K_OSC_END;
    main_k = (na == aesp_pkg::K_COLLECT || na == aesp_pkg::K_PARAM) ? aesp_pkg::K_NONE : na;
    entry_k = aesp_pkg::K_NONE;
    if (changed && ns == aesp_pkg::S_DCS_PASS) entry_k = aesp_pkg::K_HOOK;
    else if (changed && ns == aesp_pkg::S_OSC) entry_k = aesp_pkg::K_OSC_START;
    clear = changed && (ns == aesp_pkg::S_ESC || ns == aesp_pkg::S_CSI_ENTRY ||
                        ns == aesp_pkg::S_DCS_ENTRY);

    // pack the actions toward slot 0
    ops   = {3{aesp_pkg::K_NONE}};
    n_ops = 2'd0;
    if (exit_k != aesp_pkg::K_NONE) begin ops[n_ops] = exit_k; n_ops = n_ops + 2'd1; end
    if (main_k != aesp_pkg::K_NONE) begin ops[n_ops] = main_k; n_ops = n_ops + 2'd1; end
    if (entry_k != aesp_pkg::K_NONE) begin ops[n_ops] = entry_k; n_ops = n_ops + 2'd1; end

    job_o.code   = code_point_i;
    job_o.ops    = ops;
    job_o.n_ops  = n_ops;
    job_o.ibytes = ib_n;
    job_o.icount = ic_n;
    job_o.iovf   = ov_n;
    job_o.ptotal = (pc_n > 5'(aesp_pkg::PARAM_SLOTS)) ? 5'(aesp_pkg::PARAM_SLOTS) : pc_n;
    job_o.params = pv_n;
    push_o       = accept && (n_ops != 2'd0);

    state_d = state_q;
    pv_d = pv_q; pc_d = pc_q; ib_d = ib_q; ic_d = ic_q; ov_d = ov_q;
    if (accept) begin
      state_d = ns;
      if (clear) begin
        pv_d = '0; pc_d = '0; ib_d = '0; ic_d = '0; ov_d = 1'b0;
      end else begin
        pv_d = pv_n; pc_d = pc_n; ib_d = ib_n; ic_d = ic_n; ov_d = ov_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aesp_pkg::S_GROUND;
      pv_q    <= '0;
      pc_q    <= '0;
      ib_q    <= '0;
      ic_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= pv_d;
      pc_q    <= pc_d;
      ib_q    <= ib_d;
      ic_q    <= ic_d;
      ov_q    <= ov_d;
    end
  end

endmodule

// ===== hdl/aesp_queue.sv =====
// Two-entry job queue between front and back end.
// Uses aesp_pkg.
module aesp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  aesp_pkg::job_t wr_job_i,
  input  logic           pop_i,
  output aesp_pkg::job_t rd_job_o,
  output logic           full_o,
  output logic           empty_o
);

  aesp_pkg::job_t mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o   = cnt_q == 2'd2;
  assign empty_o  = cnt_q == 2'd0;
  assign rd_job_o = mem_q[rp_q];

  always_comb begin
    wp_d  = push_i ? !wp_q : wp_q;
    rp_d  = pop_i ? !rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wr_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hdl/aesp_back.sv =====
// Back end: walks a job's actions and parameter slots into a registered
// output stage, one result per cycle unless the receiver stalls or the queue is empty. Uses aesp_pkg.
module aesp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  aesp_pkg::job_t job_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [3:0]     action_kind_o,
  output logic [20:0]    char_code_o,
  output logic [7:0]     first_intermediate_o,
  output logic [7:0]     second_intermediate_o,
  output logic [1:0]     intermediate_total_o,
  output logic           intermediate_overflow_o,
  output logic [4:0]     param_total_o,
  output logic [3:0]     param_slot_o,
  output logic [15:0]    param_word_o,
  output logic           last_of_run_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] slot_q, slot_d;
  logic       valid_q, valid_d, load;
  logic [3:0] kind;
  logic       multi, seq, more_slots, last_op;
  logic [3:0]  kind_q;
  logic [20:0] code_q;
  logic [7:0]  i0_q, i1_q;
  logic [1:0]  it_q;
  logic        io_q, last_q;
  logic [4:0]  pt_q;
  logic [3:0]  ps_q;
  logic [15:0] pw_q;

  always_comb begin
    kind       = job_i.ops[phase_q];
    multi      = kind == aesp_pkg::K_CSI || kind == aesp_pkg::K_HOOK;
    seq        = multi || kind == aesp_pkg::K_ESC;
    more_slots = multi && (({1'b0, slot_q} + 5'd1) < job_i.ptotal);
    last_op    = (phase_q + 2'd1) == job_i.n_ops;
    load       = !empty_i && (!valid_q || out_ready_i);
    valid_d    = load || (valid_q && !out_ready_i);
    pop_o      = load && !more_slots && last_op;
    phase_d    = phase_q;
    slot_d     = slot_q;
    if (load) begin
      if (more_slots) slot_d = slot_q + 4'd1;
      else begin
        slot_d  = 4'd0;
        phase_d = last_op ? 2'd0 : phase_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 2'd0;
      slot_q  <= 4'd0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
      slot_q  <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind;
      code_q <= job_i.code;
      i0_q   <= (seq && job_i.icount >= 2'd1) ? job_i.ibytes[0] : 8'd0;
      i1_q   <= (seq && job_i.icount >= 2'd2) ? job_i.ibytes[1] : 8'd0;
      it_q   <= seq ? job_i.icount : 2'd0;
      io_q   <= seq && job_i.iovf;
      pt_q   <= multi ? job_i.ptotal : 5'd0;
      ps_q   <= multi ? slot_q : 4'd0;
      pw_q   <= (multi && job_i.ptotal != 5'd0) ? job_i.params[slot_q] : 16'd0;
      last_q <= !more_slots && last_op;
    end
  end

  assign out_valid_o             = valid_q;
  assign action_kind_o           = kind_q;
  assign char_code_o             = code_q;
  assign first_intermediate_o    = i0_q;
  assign second_intermediate_o   = i1_q;
  assign intermediate_total_o    = it_q;
  assign intermediate_overflow_o = io_q;
  assign param_total_o           = pt_q;
  assign param_slot_o            = ps_q;
  assign param_word_o            = pw_q;
  assign last_of_run_o           = last_q;

endmodule

// ===== hdl/ansi_escape_sequence_parser.sv =====
// Escape sequence parser top level: front end, job queue, back end.
// Jobs are queued; the back end registers their results into the output stage.
// Throughput: one item per ready cycle while each item makes at most one result.
// Results go out one at a time: exit, own and entry actions each make one, a CSI
// dispatch or hook one per parameter, or one if none. The queue then stalls.
// Reset (rst_ni low, async) puts the parser in ground and clears collectors.
module ansi_escape_sequence_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [20:0] code_point_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  action_kind_o,
  output logic [20:0] char_code_o,
  output logic [7:0]  first_intermediate_o,
  output logic [7:0]  second_intermediate_o,
  output logic [1:0]  intermediate_total_o,
  output logic        intermediate_overflow_o,
  output logic [4:0]  param_total_o,
  output logic [3:0]  param_slot_o,
  output logic [15:0] param_word_o,
  output logic        last_of_run_o
);

  // front classifies and updates state; its jobs carry a snapshot of the
  // collectors so the back end can expand them while new items arrive
  aesp_pkg::job_t wr_job, rd_job;
  logic push, pop, full, empty;

  aesp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .code_point_i,
    .q_full_i (full),
    .push_o   (push),
    .job_o    (wr_job)
  );

  aesp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i   (push),
    .wr_job_i (wr_job),
    .pop_i    (pop),
    .rd_job_o (rd_job),
    .full_o   (full),
    .empty_o  (empty)
  );

  aesp_back u_back (
    .clk_i, .rst_ni,
    .job_i   (rd_job),
    .empty_i (empty),
    .pop_o   (pop),
    .out_valid_o, .out_ready_i, .action_kind_o, .char_code_o,
    .first_intermediate_o, .second_intermediate_o, .intermediate_total_o,
    .intermediate_overflow_o, .param_total_o, .param_slot_o, .param_word_o,
    .last_of_run_o
  );

endmodule

// ===== bench/aesp_checker.sv =====
// Scoreboard for the escape sequence parser: predicts the actions of each
// accepted code point and compares them with the result port.
// Depends on aesp_pkg.
`timescale 1ns / 100ps

module aesp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [20:0] code_point_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  action_kind_i,
  input  logic [20:0] char_code_i,
  input  logic [7:0]  first_intermediate_i,
  input  logic [7:0]  second_intermediate_i,
  input  logic [1:0]  intermediate_total_i,
  input  logic        intermediate_overflow_i,
  input  logic [4:0]  param_total_i,
  input  logic [3:0]  param_slot_i,
  input  logic [15:0] param_word_i,
  input  logic        last_of_run_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [3:0]  kind;
    logic [20:0] code;
    logic [7:0]  i0;
    logic [7:0]  i1;
    logic [1:0]  itot;
    logic        iovf;
    logic [4:0]  ptot;
    logic [3:0]  slot;
    logic [15:0] word;
    logic        last;
  } action_t;

  localparam logic [3:0] K_CLEAR_SEQ = 4'd11;

  action_t               action_q[$];
  aesp_pkg::pstate_e     st;
  logic [15:0]           pval[aesp_pkg::PARAM_SLOTS];
  int                    pcnt;        // PARAM_SLOTS + 1 marks a full list
  logic [7:0]            ibuf[aesp_pkg::INTER_SLOTS];
  int                    icnt;
  logic                  iovf;

  function automatic bit is_c0(logic [20:0] c);
    return c <= 21'h17 || c == 21'h19 || (c >= 21'h1c && c <= 21'h1f);
  endfunction

  task automatic clear_seq();
    foreach (pval[k]) pval[k] = '0;
    foreach (ibuf[k]) ibuf[k] = '0;
    pcnt = 0;
    icnt = 0;
    iovf = 1'b0;
  endtask

  task automatic emit(logic [3:0] kind, logic [20:0] code, bit seq, int slot,
                      logic [15:0] word, int tot);
    action_t a;
    a.kind = kind;
    a.code = code;
    a.i0   = (seq && icnt >= 1) ? ibuf[0] : 8'd0;
    a.i1   = (seq && icnt >= 2) ? ibuf[1] : 8'd0;
    a.itot = seq ? icnt[1:0] : 2'd0;
    a.iovf = seq && iovf;
    a.ptot = tot[4:0];
    a.slot = slot[3:0];
    a.word = word;
    a.last = 1'b0;
    action_q.push_back(a);
  endtask

  task automatic apply(logic [3:0] a, logic [20:0] code, logic [20:0] c);
    int tot;
    int unsigned v;
    tot = pcnt > aesp_pkg::PARAM_SLOTS ? aesp_pkg::PARAM_SLOTS : pcnt;
    case (a)
      aesp_pkg::K_NONE: ;
      K_CLEAR_SEQ: clear_seq();
      aesp_pkg::K_COLLECT: begin
        if (icnt >= aesp_pkg::INTER_SLOTS) iovf = 1'b1;
        else begin
          ibuf[icnt] = c[7:0];
          icnt++;
        end
      end
      aesp_pkg::K_PARAM: begin
        if (pcnt <= aesp_pkg::PARAM_SLOTS) begin
          if (pcnt == 0) pcnt = 1;
          if (c == 21'h3b) begin
            if (pcnt >= aesp_pkg::PARAM_SLOTS) pcnt = aesp_pkg::PARAM_SLOTS + 1;
            else begin
              pval[pcnt] = '0;
              pcnt++;
            end
          end else begin
            v = pval[pcnt-1] * 10 + (c - 21'h30);
            pval[pcnt-1] = v > 65535 ? 16'hffff : v[15:0];
          end
        end
      end
      aesp_pkg::K_CSI, aesp_pkg::K_HOOK: begin
        if (tot == 0) emit(a, code, 1, 0, '0, 0);
        for (int k = 0; k < tot; k++) emit(a, code, 1, k, pval[k], tot);
      end
      aesp_pkg::K_ESC: emit(a, code, 1, 0, '0, 0);
      default: emit(a, code, 0, 0, '0, 0);
    endcase
  endtask

  // anywhere rules, then the rules of the current state
  task automatic predict_item(logic [20:0] code);
    logic [20:0]       c;
    aesp_pkg::pstate_e ns;
    logic [3:0]        na;
    bit                hit, dig, itm, prv;
    int                n0;
    c  = code;
    if (c >= 21'ha0 && c <= 21'hff) c = c - 21'h80;
    n0 = action_q.size();
    na = aesp_pkg::K_NONE;
    ns = st;
    hit = 1;
    dig = (c >= 21'h30 && c <= 21'h39) || c == 21'h3b;
    itm = c >= 21'h20 && c <= 21'h2f;
    prv = c >= 21'h3c && c <= 21'h3f;
    if (c == 21'h18 || c == 21'h1a || (c >= 21'h80 && c <= 21'h8f) ||
        (c >= 21'h91 && c <= 21'h97) || c == 21'h99 || c == 21'h9a) begin
      ns = aesp_pkg::S_GROUND; na = aesp_pkg::K_EXEC;
    end else if (c == 21'h9c) ns = aesp_pkg::S_GROUND;
    else if (c == 21'h98 || c == 21'h9e || c == 21'h9f) ns = aesp_pkg::S_SOS;
    else if (c == 21'h1b) ns = aesp_pkg::S_ESC;
    else if (c == 21'h90) ns = aesp_pkg::S_DCS_ENTRY;
    else if (c == 21'h9d) ns = aesp_pkg::S_OSC;
    else if (c == 21'h9b) ns = aesp_pkg::S_CSI_ENTRY;
    else begin
      hit = 0;
      case (st)
        aesp_pkg::S_GROUND: na = is_c0(c) ? aesp_pkg::K_EXEC : aesp_pkg::K_PRINT;
        aesp_pkg::S_ESC: begin
          if (is_c0(c)) na = aesp_pkg::K_EXEC;
          else if (c == 21'h7f) na = aesp_pkg::K_NONE;
          else if (itm) begin ns = aesp_pkg::S_ESC_INT; na = aesp_pkg::K_COLLECT; end
          else if (c == 21'h50) ns = aesp_pkg::S_DCS_ENTRY;
          else if (c == 21'h58 || c == 21'h5e || c == 21'h5f) ns = aesp_pkg::S_SOS;
          else if (c == 21'h5d) ns = aesp_pkg::S_OSC;
          else if (c == 21'h5b) ns = aesp_pkg::S_CSI_ENTRY;
          else if (c >= 21'h30) begin ns = aesp_pkg::S_GROUND; na = aesp_pkg::K_ESC; end
        end
        aesp_pkg::S_ESC_INT: begin
          if (is_c0(c)) na = aesp_pkg::K_EXEC;
          else if (itm) na = aesp_pkg::K_COLLECT;
          else if (c >= 21'h30 && c <= 21'h7e) begin
            ns = aesp_pkg::S_GROUND; na = aesp_pkg::K_ESC;
          end
        end
        aesp_pkg::S_CSI_ENTRY, aesp_pkg::S_CSI_PARAM: begin
          if (is_c0(c)) na = aesp_pkg::K_EXEC;
          else if (c == 21'h7f) na = aesp_pkg::K_NONE;
          else if (itm) begin ns = aesp_pkg::S_CSI_INT; na = aesp_pkg::K_COLLECT; end
          else if (dig) begin ns = aesp_pkg::S_CSI_PARAM; na = aesp_pkg::K_PARAM; end
          else if (c == 21'h3a) ns = aesp_pkg::S_CSI_IGN;
          else if (prv) begin
            if (st == aesp_pkg::S_CSI_ENTRY) begin
              ns = aesp_pkg::S_CSI_PARAM; na = aesp_pkg::K_COLLECT;
            end else ns = aesp_pkg::S_CSI_IGN;
          end else if (c >= 21'h40) begin
            ns = aesp_pkg::S_GROUND; na = aesp_pkg::K_CSI;
          end
        end
        aesp_pkg::S_CSI_INT: begin
          if (is_c0(c)) na = aesp_pkg::K_EXEC;
          else if (itm) na = aesp_pkg::K_COLLECT;
          else if (c >= 21'h30 && c <= 21'h3f) ns = aesp_pkg::S_CSI_IGN;
          else if (c >= 21'h40 && c != 21'h7f) begin
            ns = aesp_pkg::S_GROUND; na = aesp_pkg::K_CSI;
          end
        end
        aesp_pkg::S_CSI_IGN: begin
          if (is_c0(c)) na = aesp_pkg::K_EXEC;
          else if (c >= 21'h40 && c != 21'h7f) ns = aesp_pkg::S_GROUND;
        end
        aesp_pkg::S_DCS_ENTRY, aesp_pkg::S_DCS_PARAM: begin
          if (is_c0(c) || c == 21'h7f) na = aesp_pkg::K_NONE;
          else if (itm) begin ns = aesp_pkg::S_DCS_INT; na = aesp_pkg::K_COLLECT; end
          else if (dig) begin ns = aesp_pkg::S_DCS_PARAM; na = aesp_pkg::K_PARAM; end
          else if (c == 21'h3a) ns = aesp_pkg::S_DCS_IGN;
          else if (prv) begin
            if (st == aesp_pkg::S_DCS_ENTRY) begin
              ns = aesp_pkg::S_DCS_PARAM; na = aesp_pkg::K_COLLECT;
            end else ns = aesp_pkg::S_DCS_IGN;
          end else if (c >= 21'h40) ns = aesp_pkg::S_DCS_PASS;
        end
        aesp_pkg::S_DCS_INT: begin
          if (itm) na = aesp_pkg::K_COLLECT;
          else if (c >= 21'h30 && c <= 21'h3f) ns = aesp_pkg::S_DCS_IGN;
          else if (c >= 21'h40 && c != 21'h7f) ns = aesp_pkg::S_DCS_PASS;
        end
        aesp_pkg::S_DCS_PASS: if (c != 21'h7f) na = aesp_pkg::K_PUT;
        default: ;
      endcase
      hit = ns != st;
    end
    if (hit) begin
      if (st == aesp_pkg::S_DCS_PASS) apply(aesp_pkg::K_UNHOOK, code, c);
      else if (st == aesp_pkg::S_OSC) apply(aesp_pkg::K_OSC_END, code, c);
    end
    apply(na, code, c);
    if (hit) begin
      if (ns == aesp_pkg::S_ESC || ns == aesp_pkg::S_CSI_ENTRY ||
          ns == aesp_pkg::S_DCS_ENTRY)
        apply(K_CLEAR_SEQ, code, c);
      else if (ns == aesp_pkg::S_DCS_PASS) apply(aesp_pkg::K_HOOK, code, c);
      else if (ns == aesp_pkg::S_OSC) apply(aesp_pkg::K_OSC_START, code, c);
    end
    st = ns;
    if (action_q.size() > n0) action_q[$].last = 1'b1;
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    action_t e;
    if (!rst_ni) begin
      st = aesp_pkg::S_GROUND;
      clear_seq();
      action_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // compare first: results never belong to an item accepted this edge
      if (out_valid_i && out_ready_i) begin
        if (action_q.size() == 0) begin
          $error("unexpected result, action_kind %0d", action_kind_i);
          fail_count_o++;
        end else begin
          e = action_q.pop_front();
          check_field("action_kind", e.kind, action_kind_i);
          check_field("char_code", e.code, char_code_i);
          check_field("first_intermediate", e.i0, first_intermediate_i);
          check_field("second_intermediate", e.i1, second_intermediate_i);
          check_field("intermediate_total", e.itot, intermediate_total_i);
          check_field("intermediate_overflow", e.iovf, intermediate_overflow_i);
          check_field("param_total", e.ptot, param_total_i);
          check_field("param_slot", e.slot, param_slot_i);
          check_field("param_word", e.word, param_word_i);
          check_field("last_of_run", e.last, last_of_run_i);
        end
      end
      if (in_valid_i && in_ready_i) predict_item(code_point_i);
      pending_o = action_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// Top of the escape sequence parser bench: clock, reset, code point stimulus
// and verdict. Depends on aesp_pkg, aesp_checker and the parser RTL.
`timescale 1ns / 100ps

module tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [20:0] code_point_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  action_kind_o;
  logic [20:0] char_code_o;
  logic [7:0]  first_intermediate_o, second_intermediate_o;
  logic [1:0]  intermediate_total_o;
  logic        intermediate_overflow_o;
  logic [4:0]  param_total_o;
  logic [3:0]  param_slot_o;
  logic [15:0] param_word_o;
  logic        last_of_run_o;
  int          fail_count, pending;
  int          cycle_count = 0;
  bit          hold_off = 1'b0;   // long receiver stall for the pressure test

  localparam int CYCLE_LIMIT = 200000;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  ansi_escape_sequence_parser dut (.*);

  aesp_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .code_point_i,
    .out_valid_i(out_valid_o), .out_ready_i, .action_kind_i(action_kind_o),
    .char_code_i(char_code_o), .first_intermediate_i(first_intermediate_o),
    .second_intermediate_i(second_intermediate_o),
    .intermediate_total_i(intermediate_total_o),
    .intermediate_overflow_i(intermediate_overflow_o),
    .param_total_i(param_total_o), .param_slot_i(param_slot_o),
    .param_word_i(param_word_o), .last_of_run_i(last_of_run_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // stimulus list, filled up front then streamed out
  logic [20:0] code_q[$];
  int          random_items = 0;

  // receiver: stall pattern in phases, some phases never stall
  always @(posedge clk_i) begin
    int mode;
    if (rst_ni) begin
      mode = (cycle_count / 97) % 4;
      if (hold_off) out_ready_i <= 1'b0;
      else if (mode == 0) out_ready_i <= 1'b1;
      else if (mode == 1) out_ready_i <= ($urandom_range(0, 3) != 0);
      else if (mode == 2) out_ready_i <= ($urandom_range(0, 1) != 0);
      else out_ready_i <= (cycle_count % 5) < 2;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ansi_escape_sequence_parser: mismatch");
      $finish;
    end
  end

  // pressure: receiver holds off for a long stretch mid-run
  initial begin
    int n;
    wait (random_items > 60);
    hold_off = 1'b1;
    n = 0;
    while (n < 300) begin
      @(posedge clk_i);
      n++;
    end
    hold_off = 1'b0;
  end

  task automatic push_str(string s);
    foreach (s[k]) code_q.push_back(21'(s[k]));
  endtask

  function automatic logic [20:0] rand_char();
    case ($urandom_range(0, 9))
      0: return 21'($urandom_range(0, 31));
      1: return 21'($urandom_range(21'h80, 21'hff));
      2: return 21'($urandom_range(21'h100, 21'h1fffff));
      3: return 21'($urandom_range(21'h20, 21'h2f));
      default: return 21'($urandom_range(21'h20, 21'h7f));
    endcase
  endfunction

  // one well-formed sequence with random content, sometimes broken
  task automatic push_sequence();
    int np;
    case ($urandom_range(0, 5))
      0: begin  // CSI with params
        code_q.push_back($urandom_range(0, 1) ? 21'h9b : 21'h1b);
        if (code_q[$] == 21'h1b) code_q.push_back(21'h5b);
        if ($urandom_range(0, 3) == 0) code_q.push_back(21'($urandom_range(21'h3c, 21'h3f)));
        np = $urandom_range(0, 5);
        repeat (np) begin
          repeat ($urandom_range(0, 3)) code_q.push_back(21'($urandom_range(21'h30, 21'h39)));
          code_q.push_back(21'h3b);
        end
        repeat ($urandom_range(0, 3)) code_q.push_back(21'($urandom_range(21'h20, 21'h2f)));
        code_q.push_back(21'($urandom_range(21'h40, 21'h7e)));
      end
      1: begin  // DCS passthrough
        code_q.push_back(21'h90);
        repeat ($urandom_range(0, 3)) code_q.push_back(21'($urandom_range(21'h30, 21'h3b)));
        code_q.push_back(21'($urandom_range(21'h40, 21'h7e)));
        repeat ($urandom_range(0, 4)) code_q.push_back(rand_char());
        code_q.push_back(21'h9c);
      end
      2: begin  // ESC with intermediates
        code_q.push_back(21'h1b);
        repeat ($urandom_range(0, 3)) code_q.push_back(21'($urandom_range(21'h20, 21'h2f)));
        code_q.push_back(21'($urandom_range(21'h30, 21'h7e)));
      end
      3: begin  // OSC string (a 0xdd start folds to a print)
        code_q.push_back($urandom_range(0, 1) ? 21'h9d : 21'hdd);
        repeat ($urandom_range(0, 4)) code_q.push_back(21'($urandom_range(21'h20, 21'h7e)));
        code_q.push_back(21'h9c);
      end
      default: repeat ($urandom_range(1, 4)) code_q.push_back(rand_char());
    endcase
  endtask

  initial begin
    int gap, burst, settle;
    // directed part
    push_str("A");
    code_q.push_back(21'h1fffff);
    code_q.push_back(21'h10ffff);
    code_q.push_back(21'h0d);
    code_q.push_back(21'hc1);                    // folded print
    code_q.push_back(21'h9b); push_str(";99999;7m");  // leading separator, saturation
    code_q.push_back(21'h9b); push_str("?");     // private marker
    repeat (17) push_str("1;");                  // list overflow
    push_str("H");
    code_q.push_back(21'h1b); push_str("!\"#$q"); // intermediate overflow
    code_q.push_back(21'h90); push_str("1;2|xy");
    code_q.push_back(21'h1b); push_str("\\");    // unhook via ESC
    code_q.push_back(21'h1b); push_str("]0;t");
    code_q.push_back(21'h18);                    // cancel ends OSC
    code_q.push_back(21'h98); push_str("zz"); code_q.push_back(21'h9c);
    code_q.push_back(21'h9b); code_q.push_back(21'h1fffff);  // big-code dispatch
    code_q.push_back(21'h9b); push_str("1:2m");  // colon goes to ignore
    code_q.push_back(21'h7f);
    code_q.push_back(21'h1b); code_q.push_back(21'h7f); push_str("7");
    // random part
    while (code_q.size() < 170) push_sequence();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    while (code_q.size() > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && code_q.size() > 0) begin
        in_valid_i   <= 1'b1;
        code_point_i <= code_q.pop_front();
        @(posedge clk_i);
        while (!in_ready_o) @(posedge clk_i);
        random_items++;
        burst--;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    while (pending > 0 || hold_off) @(posedge clk_i);
    settle = 0;
    while (settle < 20) begin
      @(posedge clk_i);
      settle++;
    end
    if (fail_count == 0 && pending == 0) begin
      $display("ansi_escape_sequence_parser: match");
    end else begin
      $display("ansi_escape_sequence_parser: mismatch");
    end
    $finish;
  end

endmodule

// ===== ansi_escape_sequence_parser.f =====
hdl/aesp_pkg.sv
hdl/aesp_front.sv
hdl/aesp_queue.sv
hdl/aesp_back.sv
hdl/ansi_escape_sequence_parser.sv
bench/aesp_checker.sv
bench/tb.sv
